// ===== src/min_pair_distance_fluid_points_defines.svh =====
// Assertion macros used by mpd_dp.
`ifndef MIN_PAIR_DISTANCE_FLUID_POINTS_DEFINES_SVH
`define MIN_PAIR_DISTANCE_FLUID_POINTS_DEFINES_SVH

// Same-cycle implication.
`define MPD_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define MPD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/mpd_pkg.sv =====
package mpd_pkg;

  localparam int unsigned SQ_BITS   = 50;
  localparam int unsigned DIST_BITS = 25;

  typedef struct packed {
    logic latch;
    logic scan_rd;
    logic store;
    logic sqrt_start;
    logic emit;
  } mpd_cmd_t;

  typedef struct packed {
    logic fluid;
    logic last;
    logic cnt_zero;
    logic cnt_full;
    logic scan_end;
    logic pipe_busy;
    logic sqrt_done;
    logic out_free;
  } mpd_sts_t;

endpackage

// ===== src/mpd_isqrt.sv =====
module mpd_isqrt #(
  parameter int unsigned RW = 25
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [2*RW-1:0] radicand_i,
  output logic            done_o,
  output logic [RW-1:0]   root_o
);

  localparam int unsigned CW = $clog2(RW + 1);

  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic [2*RW-1:0] rad_q, rad_d;
  logic [RW+1:0]   rem_q, rem_d;
  logic [RW-1:0]   root_q, root_d;
  logic [RW+1:0]   rem_sh;
  logic [RW+1:0]   trial;

  assign rem_sh = {rem_q[RW-1:0], rad_q[2*RW-1 -: 2]};
  assign trial  = {root_q, 2'b01};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rad_d  = rad_q;
    rem_d  = rem_q;
    root_d = root_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CW'(RW);
      rad_d  = radicand_i;
      rem_d  = '0;
      root_d = '0;
    end else if (busy_q) begin
      rad_d = {rad_q[2*RW-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_d  = rem_sh - trial;
        root_d = {root_q[RW-2:0], 1'b1};
      end else begin
        rem_d  = rem_sh;
        root_d = {root_q[RW-2:0], 1'b0};
      end
      cnt_d = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q  <= rad_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

// ===== src/mpd_ctrl.sv =====
module mpd_ctrl
  import mpd_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  mpd_sts_t sts_i,
  output mpd_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_SCAN,
    S_DRAIN,
    S_WRAP,
    S_ROOT,
    S_EMIT
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        state_d = (sts_i.fluid && !sts_i.cnt_zero) ? S_SCAN : S_WRAP;
      end
      S_SCAN: begin
        cmd_o.scan_rd = 1'b1;
        if (sts_i.scan_end) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!sts_i.pipe_busy) begin
          state_d = S_WRAP;
        end
      end
      S_WRAP: begin
        cmd_o.store = sts_i.fluid && !sts_i.cnt_full;
        if (sts_i.last) begin
          cmd_o.sqrt_start = 1'b1;
          state_d          = S_ROOT;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_ROOT: begin
        if (sts_i.sqrt_done) begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

endmodule

// ===== src/mpd_dp.sv =====
`include "min_pair_distance_fluid_points_defines.svh"

module mpd_dp
  import mpd_pkg::*;
#(
  parameter int unsigned MAX_POINTS = 1024,
  parameter int unsigned COORD_BITS = 24
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [COORD_BITS-1:0] x_coord_i,
  input  logic [COORD_BITS-1:0] y_coord_i,
  input  logic [COORD_BITS-1:0] z_coord_i,
  input  logic                  is_fluid_i,
  input  logic                  last_point_i,
  input  mpd_cmd_t              cmd_i,
  output mpd_sts_t              sts_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [DIST_BITS-1:0]  min_dist_o,
  output logic [SQ_BITS-1:0]    min_dist_sq_o,
  output logic                  pair_found_o
);

  localparam int unsigned AW     = $clog2(MAX_POINTS);
  localparam int unsigned CNTW   = $clog2(MAX_POINTS + 1);
  localparam int unsigned DW     = COORD_BITS + 1;
  localparam int unsigned RW     = COORD_BITS + 1;
  localparam int unsigned D2W    = 2 * RW;
  localparam int unsigned PW     = 2 * COORD_BITS + 1;
  localparam int unsigned SQ_EXT = (D2W > SQ_BITS) ? D2W : SQ_BITS;
  localparam int unsigned RT_EXT = (RW > DIST_BITS) ? RW : DIST_BITS;

  logic [COORD_BITS-1:0] x_mem [MAX_POINTS];
  logic [COORD_BITS-1:0] y_mem [MAX_POINTS];
  logic [COORD_BITS-1:0] z_mem [MAX_POINTS];

  logic [COORD_BITS-1:0] px_q, py_q, pz_q;
  logic                  fluid_q, last_q;
  logic [CNTW-1:0]       count_q, count_d;
  logic [AW-1:0]         idx_q, idx_d;

  logic                  v1_q, v2_q, v3_q, v4_q;
  logic [COORD_BITS-1:0] rx_q, ry_q, rz_q;
  logic signed [DW-1:0]  dx_q, dy_q, dz_q;
  logic signed [2*DW-1:0] prod_x, prod_y, prod_z;
  logic [PW-1:0]         sqx_q, sqy_q, sqz_q;
  logic [D2W-1:0]        sum_q;
  logic [D2W-1:0]        best_q, best_d;
  logic                  best_valid_q, best_valid_d;

  logic                  sqrt_done;
  logic [RW-1:0]         root;

  logic [SQ_EXT-1:0]     best_ext;
  logic [RT_EXT-1:0]     root_ext;
  logic [SQ_BITS-1:0]    sq_sat;
  logic [DIST_BITS-1:0]  dist_sat;

  logic                  out_valid_q;
  logic [DIST_BITS-1:0]  dist_q;
  logic [SQ_BITS-1:0]    sq_q;
  logic                  found_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      px_q <= x_coord_i;
      py_q <= y_coord_i;
      pz_q <= z_coord_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fluid_q <= 1'b0;
      last_q  <= 1'b0;
    end else if (cmd_i.latch) begin
      fluid_q <= is_fluid_i;
      last_q  <= last_point_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_rd) begin
      rx_q <= x_mem[idx_q];
      ry_q <= y_mem[idx_q];
      rz_q <= z_mem[idx_q];
    end
    if (cmd_i.store) begin
      x_mem[count_q[AW-1:0]] <= px_q;
      y_mem[count_q[AW-1:0]] <= py_q;
      z_mem[count_q[AW-1:0]] <= pz_q;
    end
  end

  assign prod_x = dx_q * dx_q;
  assign prod_y = dy_q * dy_q;
  assign prod_z = dz_q * dz_q;

  always_ff @(posedge clk_i) begin
    dx_q  <= $signed({px_q[COORD_BITS-1], px_q}) - $signed({rx_q[COORD_BITS-1], rx_q});
    dy_q  <= $signed({py_q[COORD_BITS-1], py_q}) - $signed({ry_q[COORD_BITS-1], ry_q});
    dz_q  <= $signed({pz_q[COORD_BITS-1], pz_q}) - $signed({rz_q[COORD_BITS-1], rz_q});
    sqx_q <= prod_x[PW-1:0];
    sqy_q <= prod_y[PW-1:0];
    sqz_q <= prod_z[PW-1:0];
    sum_q <= D2W'(sqx_q) + D2W'(sqy_q) + D2W'(sqz_q);
  end

  always_comb begin
    idx_d = idx_q;
    if (cmd_i.latch) begin
      idx_d = '0;
    end else if (cmd_i.scan_rd) begin
      idx_d = idx_q + AW'(1);
    end
  end

  always_comb begin
    count_d = count_q;
    if (cmd_i.emit) begin
      count_d = '0;
    end else if (cmd_i.store) begin
      count_d = count_q + CNTW'(1);
    end
  end

  always_comb begin
    best_d       = best_q;
    best_valid_d = best_valid_q;
    if (cmd_i.emit) begin
      best_d       = '0;
      best_valid_d = 1'b0;
    end else if (v4_q && (!best_valid_q || (sum_q < best_q))) begin
      best_d       = sum_q;
      best_valid_d = 1'b1;
    end
  end

  mpd_isqrt #(
    .RW (RW)
  ) u_isqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.sqrt_start),
    .radicand_i (best_q),
    .done_o     (sqrt_done),
    .root_o     (root)
  );

  assign best_ext = SQ_EXT'(best_q);
  assign root_ext = RT_EXT'(root);
  assign sq_sat   = (best_ext > SQ_EXT'({SQ_BITS{1'b1}})) ? '1 : best_ext[SQ_BITS-1:0];
  assign dist_sat = (root_ext > RT_EXT'({DIST_BITS{1'b1}})) ? '1 : root_ext[DIST_BITS-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q        <= '0;
      count_q      <= '0;
      best_q       <= '0;
      best_valid_q <= 1'b0;
      v1_q         <= 1'b0;
      v2_q         <= 1'b0;
      v3_q         <= 1'b0;
      v4_q         <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      idx_q        <= idx_d;
      count_q      <= count_d;
      best_q       <= best_d;
      best_valid_q <= best_valid_d;
      v1_q         <= cmd_i.scan_rd;
      v2_q         <= v1_q;
      v3_q         <= v2_q;
      v4_q         <= v3_q;
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      dist_q  <= best_valid_q ? dist_sat : '0;
      sq_q    <= best_valid_q ? sq_sat : '0;
      found_q <= best_valid_q;
    end
  end

  always_comb begin
    sts_o.fluid     = fluid_q;
    sts_o.last      = last_q;
    sts_o.cnt_zero  = (count_q == '0);
    sts_o.cnt_full  = (count_q == CNTW'(MAX_POINTS));
    sts_o.scan_end  = (CNTW'(idx_q) == (count_q - CNTW'(1)));
    sts_o.pipe_busy = v1_q | v2_q | v3_q | v4_q;
    sts_o.sqrt_done = sqrt_done;
    sts_o.out_free  = !out_valid_q || out_ready_i;
  end

  assign out_valid_o   = out_valid_q;
  assign min_dist_o    = dist_q;
  assign min_dist_sq_o = sq_q;
  assign pair_found_o  = found_q;

  `MPD_ASSERT_SAME(a_count_bound, clk_i, rst_ni, 1'b1, count_q <= CNTW'(MAX_POINTS), "store count above capacity")
  `MPD_ASSERT_NEXT(a_emit_clears, clk_i, rst_ni, cmd_i.emit, (count_q == '0) && !best_valid_q, "set not emptied after result")
  `MPD_ASSERT_SAME(a_cmp_has_points, clk_i, rst_ni, v4_q, count_q != '0, "distance compare with empty store")

endmodule

// ===== src/min_pair_distance_fluid_points.sv =====
// Channel | Direction | Handshake              | Payload
// in      | input     | in_valid_i / in_ready_o   | x_coord_i, y_coord_i, z_coord_i,
//         |           |                           | is_fluid_i, last_point_i
// out     | output    | out_valid_o / out_ready_i | min_dist_o, min_dist_sq_o, pair_found_o
//
// A fluid point is compared with every stored point (one store read per stored
// point, then a four-stage distance pipeline drains); other points skip the scan.
// A last point then runs the bit-serial square root of the minimum, one bit a cycle.
// Reset empties the set; the point stores need no clearing, only entries below the
// stored count are read.
// The result sits in an output register; new points are taken while it waits, and a
// later result waits for that register to drain.
module min_pair_distance_fluid_points
  import mpd_pkg::*;
#(
  parameter int unsigned MAX_POINTS = 1024,
  parameter int unsigned COORD_BITS = 24
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic signed [COORD_BITS-1:0] x_coord_i,
  input  logic signed [COORD_BITS-1:0] y_coord_i,
  input  logic signed [COORD_BITS-1:0] z_coord_i,
  input  logic                         is_fluid_i,
  input  logic                         last_point_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [DIST_BITS-1:0]         min_dist_o,
  output logic [SQ_BITS-1:0]           min_dist_sq_o,
  output logic                         pair_found_o
);

  mpd_cmd_t cmd;
  mpd_sts_t sts;

  mpd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  mpd_dp #(
    .MAX_POINTS (MAX_POINTS),
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .x_coord_i     (x_coord_i),
    .y_coord_i     (y_coord_i),
    .z_coord_i     (z_coord_i),
    .is_fluid_i    (is_fluid_i),
    .last_point_i  (last_point_i),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .min_dist_o    (min_dist_o),
    .min_dist_sq_o (min_dist_sq_o),
    .pair_found_o  (pair_found_o)
  );

endmodule
